/* rtl/assert_macros.svh */
// Assertion macros for the checker file.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, masked while reset is low.
`define DSTS_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("dsts assertion failed");

// Clocked assertion that is also checked during reset.
`define DSTS_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("dsts reset assertion failed");

`endif

/* rtl/dsts_pkg.sv */
// Package for the daily schedule trigger scan: payload structs, day constants,
// and the per-entry evaluation result type. No dependencies.
`timescale 1ns / 1ps

package dsts_pkg;

  localparam int MINUTES_PER_DAY = 60 * 24;
  localparam int HALF_DAY        = MINUTES_PER_DAY / 2;
  localparam int MINUTE_W        = 11;
  localparam int WINDOW_W        = 10;
  localparam int WAIT_W          = 11;
  localparam int WAIT_MAX        = (1 << WAIT_W) - 1;
  localparam int WINDOW_RESET    = 1;
  // signed width for minute differences and wait sums
  localparam int DIFF_W          = MINUTE_W + 2;

  localparam int CFG_ADDR_W      = 3;
  localparam int CFG_DATA_W      = 32;

  // register index codes (byte address >> 2)
  localparam logic REG_TRIGGER_WINDOW = 1'b0;

  typedef struct packed {
    logic [MINUTE_W-1:0] entry_minute;
    logic                empty_slot;
    logic [MINUTE_W-1:0] now_minute;
    logic                last_entry;
  } dsts_in_t;

  typedef struct packed {
    logic              trigger;
    logic              wait_valid;
    logic [WAIT_W-1:0] wait_len;
  } dsts_out_t;

  // evaluation of one entry against the present minute
  typedef struct packed {
    logic              hit;
    logic [WAIT_W-1:0] need;
    logic [WAIT_W-1:0] fwd;
  } dsts_eval_t;

endpackage

/* rtl/dsts_cfg.sv */
// APB-style register block holding trigger_window.
// Depends on dsts_pkg.
`timescale 1ns / 1ps

module dsts_cfg import dsts_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  output logic [WINDOW_W-1:0]   window
);

  logic [WINDOW_W-1:0] window_r;
  logic [WINDOW_W-1:0] window_nxt;
  logic                wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_comb begin
    window_nxt = window_r;
    if (wr_en) begin
      unique case (paddr[CFG_ADDR_W-1])
        REG_TRIGGER_WINDOW: window_nxt = pwdata[WINDOW_W-1:0];
        default:            window_nxt = window_r;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[CFG_ADDR_W-1])
      REG_TRIGGER_WINDOW: prdata = CFG_DATA_W'(window_r);
      default:            prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= WINDOW_W'(WINDOW_RESET);
    end else begin
      window_r <= window_nxt;
    end
  end

  assign window = window_r;

endmodule

/* rtl/dsts_entry.sv */
// Per-entry evaluation: clamp minutes, nearest-day difference, window test,
// minimum wait and forward wait. Depends on dsts_pkg.
`timescale 1ns / 1ps

module dsts_entry import dsts_pkg::*; (
  input  logic [MINUTE_W-1:0] entry_minute,
  input  logic [MINUTE_W-1:0] now_minute,
  input  logic [WINDOW_W-1:0] window,
  output dsts_eval_t          eval
);

  localparam logic [MINUTE_W-1:0]      MinuteMax = MINUTE_W'(MINUTES_PER_DAY - 1);
  localparam logic signed [DIFF_W-1:0] DayS      = DIFF_W'(MINUTES_PER_DAY);
  localparam logic signed [DIFF_W-1:0] HalfS     = DIFF_W'(HALF_DAY);
  localparam logic signed [DIFF_W-1:0] WaitMaxS  = DIFF_W'(WAIT_MAX);

  logic [MINUTE_W-1:0]      ev;
  logic [MINUTE_W-1:0]      now;
  logic signed [DIFF_W-1:0] diff;
  logic signed [DIFF_W-1:0] near;
  logic signed [DIFF_W-1:0] mag;
  logic signed [DIFF_W-1:0] win_s;
  logic signed [DIFF_W-1:0] need;
  logic signed [DIFF_W-1:0] fwd;

  always_comb begin
    ev    = (entry_minute > MinuteMax) ? MinuteMax : entry_minute;
    now   = (now_minute > MinuteMax) ? MinuteMax : now_minute;
    diff  = $signed({2'b00, ev}) - $signed({2'b00, now});
    win_s = $signed(DIFF_W'(window));

    near = diff;
    if (near <= -HalfS) near = near + DayS;
    if (near > HalfS)   near = near - DayS;
    mag = (near < 0) ? -near : near;

    need = near + win_s + DIFF_W'(1);
    fwd  = (diff < 0) ? diff + DayS : diff;

    eval.hit  = (mag <= win_s);
    eval.need = (need > WaitMaxS) ? WAIT_W'(WAIT_MAX) : need[WAIT_W-1:0];
    eval.fwd  = (fwd > WaitMaxS) ? WAIT_W'(WAIT_MAX) : fwd[WAIT_W-1:0];
  end

endmodule

/* rtl/daily_schedule_trigger_scan_top.sv */
// Daily schedule trigger scan, top level: input register, scan state, result
// register. Depends on dsts_pkg, dsts_cfg and dsts_entry.
//
// Usage: each schedule slot is one beat on the in_ channel (valid/ready),
// carrying the slot's event minute, the empty flag, the present minute and
// the last-slot flag. Every accepted beat gives exactly one beat on the out_
// channel: trigger says the slot's event fires now; on the slot flagged last,
// wait_valid is set and wait_len holds the wait before the next scan.
// trigger_window sits at byte address 0 of the APB port, reset value 1; write
// it only while no beat is in flight.
// Path: an accepted input beat goes to the input register, then to the result
// register. Throughput: one beat per cycle while the result register drains
// (see Stall); the scan state (soonest wait, minimum wait, stopped flag) is
// read and updated in the same cycle that loads the result register.
// Reset: synchronous, active low; both pipeline stages empty, scan state set
// for a fresh scan (minimum wait 1), trigger_window back to 1.
// Stall: while out_ready is low a held result keeps its value; the input
// register still takes one more beat, then in_ready drops until the result
// register drains.
`timescale 1ns / 1ps

module daily_schedule_trigger_scan_top import dsts_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  dsts_in_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output dsts_out_t             out_data,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  logic [WINDOW_W-1:0] window;
  dsts_eval_t          eval;

  logic                s0_valid_r;
  dsts_in_t            s0_data_r;
  logic                out_valid_r;
  dsts_out_t           out_data_r;
  dsts_out_t           out_data_nxt;

  logic [WAIT_W-1:0]   soonest_r;
  logic [WAIT_W-1:0]   soonest_nxt;
  logic [WAIT_W-1:0]   least_r;
  logic [WAIT_W-1:0]   least_nxt;
  logic                stopped_r;
  logic                stopped_nxt;

  logic                advance;
  logic                in_fire;

  dsts_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .window  (window)
  );

  dsts_entry u_entry (
    .entry_minute (s0_data_r.entry_minute),
    .now_minute   (s0_data_r.now_minute),
    .window       (window),
    .eval         (eval)
  );

  assign advance  = s0_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s0_valid_r || advance;
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    soonest_nxt  = soonest_r;
    least_nxt    = least_r;
    stopped_nxt  = stopped_r;
    out_data_nxt = '0;

    if (!stopped_r && s0_data_r.empty_slot) begin
      stopped_nxt = 1'b1;
    end else if (!stopped_r) begin
      if (eval.hit) begin
        out_data_nxt.trigger = 1'b1;
        if (eval.need > least_r) least_nxt = eval.need;
      end else if (soonest_r == '0 || eval.fwd < soonest_r) begin
        soonest_nxt = eval.fwd;
      end
    end

    if (s0_data_r.last_entry) begin
      out_data_nxt.wait_valid = 1'b1;
      out_data_nxt.wait_len   = (soonest_nxt < least_nxt) ? least_nxt : soonest_nxt;
      // scan done: back to a fresh scan
      soonest_nxt = '0;
      least_nxt   = WAIT_W'(1);
      stopped_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      soonest_r   <= '0;
      least_r     <= WAIT_W'(1);
      stopped_r   <= 1'b0;
    end else begin
      if (in_fire) begin
        s0_valid_r <= 1'b1;
      end else if (advance) begin
        s0_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
        soonest_r   <= soonest_nxt;
        least_r     <= least_nxt;
        stopped_r   <= stopped_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s0_data_r <= in_data;
    end
    if (advance) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* rtl/dsts_checker.sv */
// Port-level checker for the daily schedule trigger scan, bound to the top.
// Depends on dsts_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dsts_checker import dsts_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      out_valid,
  input logic      out_ready,
  input dsts_out_t out_data
);

  // a stalled result beat holds
  `DSTS_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_data))

  // only a last-slot beat carries a wait
  `DSTS_ASSERT(a_wait_zero, clk, rst_n, out_valid && !out_data.wait_valid |-> out_data.wait_len == '0)

  // a reported wait is never zero (minimum wait starts at one)
  `DSTS_ASSERT(a_wait_nonzero, clk, rst_n, out_valid && out_data.wait_valid |-> out_data.wait_len != '0)

  // reset empties the result register
  `DSTS_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_valid)

endmodule

bind daily_schedule_trigger_scan_top dsts_checker u_dsts_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

/* tb/daily_schedule_trigger_scan_top_tb.sv */
// Self-checking testbench for daily_schedule_trigger_scan_top: directed slots, then random
// schedule scans under sender gaps, receiver stalls and trigger_window changes.
// Depends on dsts_pkg and the RTL top level only.
`timescale 1ns / 1ps

module daily_schedule_trigger_scan_top_tb;
  import dsts_pkg::*;

  localparam int RANDOM_SLOTS   = 750;
  localparam int IDLE_LIMIT     = 1000;
  localparam int SETTLE_CYCLES  = 4;
  localparam int MAX_PRINTED    = 20;
  localparam logic [CFG_ADDR_W-1:0] WINDOW_ADDR   = {REG_TRIGGER_WINDOW, 2'b00};
  localparam logic [CFG_ADDR_W-1:0] UNMAPPED_ADDR = 3'd4;

  typedef enum int {READY_ALWAYS, READY_RANDOM, READY_PERIODIC, READY_LONG} ready_mode_e;

  typedef struct packed {
    logic        set_win;
    logic [31:0] win_raw;
    dsts_in_t    slot;
    logic        typed;
    dsts_out_t   want;
  } plan_row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  dsts_in_t              in_data;
  logic                  out_valid;
  logic                  out_ready;
  dsts_out_t             out_data;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  // predictor state
  int unsigned window_q;
  int unsigned soonest_q;
  int unsigned least_q;
  bit          halted_q;

  dsts_out_t   due_results[$];
  plan_row_t   plan[$];
  dsts_out_t   want_q;

  int          errors;
  int          burst_left;
  bit          steady;
  int          live_slots;
  int          scans;
  int          window_writes;
  int          results_seen;
  int          triggers_seen;
  int          waits_seen;
  int          idle_cycles;
  int          ready_cyc;
  ready_mode_e ready_mode;

  daily_schedule_trigger_scan_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  task automatic report_mismatch(string msg);
    errors++;
    if (errors <= MAX_PRINTED) $display("ERROR @%0t: %s", $time, msg);
  endtask

  function automatic int clamp_minute(logic [MINUTE_W-1:0] m);
    return (m > MINUTES_PER_DAY - 1) ? MINUTES_PER_DAY - 1 : int'(m);
  endfunction

  // Expected beat for one slot; advances the scan state.
  function automatic dsts_out_t predict_slot(dsts_in_t s);
    int ev, now, d, mag, fwd, need;
    dsts_out_t r;
    r = '0;
    if (!halted_q && s.empty_slot) begin
      halted_q = 1'b1;
    end else if (!halted_q) begin
      ev  = clamp_minute(s.entry_minute);
      now = clamp_minute(s.now_minute);
      d   = ev - now;
      if (d <= -HALF_DAY) d += MINUTES_PER_DAY;
      if (d > HALF_DAY) d -= MINUTES_PER_DAY;
      mag = (d < 0) ? -d : d;
      if (mag <= int'(window_q)) begin
        need = d + int'(window_q) + 1;
        if (need > WAIT_MAX) need = WAIT_MAX;
        if (need > int'(least_q)) least_q = need;
        r.trigger = 1'b1;
      end else begin
        fwd = ev - now;
        if (fwd < 0) fwd += MINUTES_PER_DAY;
        if (fwd > WAIT_MAX) fwd = WAIT_MAX;
        if (soonest_q == 0 || fwd < int'(soonest_q)) soonest_q = fwd;
      end
    end
    if (s.last_entry) begin
      r.wait_valid = 1'b1;
      r.wait_len   = WAIT_W'((soonest_q < least_q) ? least_q : soonest_q);
      soonest_q    = 0;
      least_q      = 1;
      halted_q     = 1'b0;
    end
    return r;
  endfunction

  task automatic push_slot(dsts_in_t s, logic typed, dsts_out_t want);
    int gap;
    dsts_out_t p;
    if (burst_left == 0) begin
      gap = steady ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        @(negedge clk);
        in_valid = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    @(negedge clk);
    in_valid = 1'b1;
    in_data  = s;
    do @(posedge clk); while (in_ready !== 1'b1);
    if (!halted_q) live_slots++;
    p = predict_slot(s);
    due_results.push_back(typed ? want : p);
  endtask

  // Stop sending and let every outstanding result come back.
  task automatic settle_pipe();
    @(negedge clk);
    in_valid = 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    burst_left = 0;
  endtask

  task automatic apb_write(logic [CFG_ADDR_W-1:0] a, logic [31:0] v);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = a;
    pwdata  = v;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    if (a[CFG_ADDR_W-1:2] == REG_TRIGGER_WINDOW) window_q = v & 32'h3FF;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  task automatic apb_check_window();
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = WINDOW_ADDR;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    if (prdata !== CFG_DATA_W'(window_q))
      report_mismatch($sformatf("trigger_window reads %0d, expected %0d", prdata, window_q));
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  task automatic reprogram(logic [31:0] raw);
    settle_pipe();
    apb_write(WINDOW_ADDR, raw);
    apb_check_window();
    window_writes++;
  endtask

  task automatic add_row(logic set_win, logic [31:0] raw, int em, logic es, int cm, logic le,
                         logic typed, logic t, logic v, int w);
    plan_row_t r;
    r.set_win           = set_win;
    r.win_raw           = raw;
    r.slot.entry_minute = MINUTE_W'(em);
    r.slot.empty_slot   = es;
    r.slot.now_minute   = MINUTE_W'(cm);
    r.slot.last_entry   = le;
    r.typed             = typed;
    r.want.trigger      = t;
    r.want.wait_valid   = v;
    r.want.wait_len     = WAIT_W'(w);
    plan.push_back(r);
  endtask

  function automatic int pick_minute();
    return ($urandom_range(0, 15) == 0) ? $urandom_range(MINUTES_PER_DAY, 2047)
                                        : $urandom_range(0, MINUTES_PER_DAY - 1);
  endfunction

  // result checking and watchdog
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (due_results.size() == 0) begin
        report_mismatch("result beat with nothing expected");
      end else begin
        want_q = due_results.pop_front();
        if (want_q.trigger) triggers_seen++;
        if (want_q.wait_valid) waits_seen++;
        if (out_data.trigger !== want_q.trigger)
          report_mismatch($sformatf("trigger %b, expected %b", out_data.trigger, want_q.trigger));
        if (out_data.wait_valid !== want_q.wait_valid)
          report_mismatch($sformatf("wait_valid %b, expected %b",
                                    out_data.wait_valid, want_q.wait_valid));
        if (out_data.wait_len !== want_q.wait_len)
          report_mismatch($sformatf("wait_len %0d, expected %0d",
                                    out_data.wait_len, want_q.wait_len));
      end
    end
    if ((in_valid && in_ready) || (out_valid && out_ready) || psel) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no beat for %0d cycles, %0d results outstanding",
               IDLE_LIMIT, due_results.size());
      $display("FAILURE");
      $finish;
    end
  end

  // receiver backpressure, with the pattern picked at random among four modes
  always @(negedge clk) begin
    ready_cyc++;
    if (ready_cyc % 100 == 0) ready_mode = ready_mode_e'($urandom_range(0, 3));
    case (ready_mode)
      READY_ALWAYS:   out_ready = 1'b1;
      READY_RANDOM:   out_ready = ($urandom_range(0, 2) != 0);
      READY_PERIODIC: out_ready = (ready_cyc % 5 != 0);
      default:        out_ready = (ready_cyc % 16 < 8);
    endcase
  end

  initial begin
    dsts_in_t s;
    int len, now, off, e;
    bit noise;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    out_ready  = 1'b1;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    ready_mode = READY_ALWAYS;
    window_q   = WINDOW_RESET;
    soonest_q  = 0;
    least_q    = 1;
    halted_q   = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset value, then an unmapped write must leave it alone
    apb_check_window();
    apb_write(UNMAPPED_ADDR, 32'h0000_0000);
    apb_check_window();

    // window at reset value 1
    add_row(0, 0,    0, 1,    0, 1, 1, 0, 1,    1);  // empty scan
    add_row(0, 0,    0, 0,    0, 1, 1, 1, 1,    2);  // exact hit
    add_row(0, 0,    5, 0,    0, 1, 1, 0, 1,    5);
    add_row(0, 0,    0, 0, 1439, 1, 1, 1, 1,    3);  // hit across midnight
    add_row(0, 0, 2047, 0, 2047, 1, 1, 1, 1,    2);  // both minutes clamped
    add_row(0, 0, 1500, 0,    0, 1, 1, 1, 1,    1);  // clamped to one before midnight
    add_row(0, 0,  100, 0,    0, 0, 1, 0, 0,    0);
    add_row(0, 0,   50, 0,    0, 0, 1, 0, 0,    0);
    add_row(0, 0,    0, 1,    0, 0, 1, 0, 0,    0);  // stops the scan
    add_row(0, 0,    0, 0,    0, 0, 1, 0, 0,    0);  // ignored
    add_row(0, 0,    0, 0,    0, 1, 1, 0, 1,   50);
    add_row(0, 0,  720, 0,    0, 1, 0, 0, 0,    0);  // half a day ahead
    add_row(0, 0,    0, 0,  720, 1, 0, 0, 0,    0);  // half a day behind
    add_row(1, 720,  720, 0,    0, 1, 1, 1, 1, 1441);
    add_row(0, 0,    0, 0,  720, 1, 1, 1, 1, 1441);
    add_row(0, 0, 1439, 0,    0, 0, 0, 0, 0,    0);
    add_row(0, 0,    2, 0, 1000, 1, 0, 0, 0,    0);
    add_row(1, 0,  300, 0,  300, 1, 1, 1, 1,    1);
    add_row(0, 0,  301, 0,  300, 0, 0, 0, 0,    0);
    add_row(0, 0,  299, 0,  300, 1, 0, 0, 0,    0);
    add_row(1, 32'hFFFF_FFFF, 720, 0, 0, 1, 1, 1, 1, 1744);  // window masks to 1023
    add_row(0, 0,    0, 0,    1, 0, 0, 0, 0,    0);
    add_row(0, 0, 1024, 1, 2047, 1, 0, 0, 0,    0);  // empty slot as last
    add_row(1, 32'h0000_0405, 10, 0, 3, 1, 0, 0, 0, 0);  // upper pwdata bits dropped
    foreach (plan[i]) begin
      if (plan[i].set_win) reprogram(plan[i].win_raw);
      push_slot(plan[i].slot, plan[i].typed, plan[i].want);
    end

    // random scans
    live_slots = 0;
    while (live_slots < RANDOM_SLOTS) begin
      scans++;
      if (scans % 12 == 0) begin
        case ($urandom_range(0, 5))
          0:       reprogram(32'd0);
          1:       reprogram(32'd1);
          2:       reprogram(32'd720);
          3:       reprogram(32'd1023);
          4:       reprogram($urandom_range(0, 720));
          default: reprogram($urandom);
        endcase
        // pipe is empty here after the reprogram
        if (scans % 36 == 0) apb_write(UNMAPPED_ADDR, $urandom);
      end
      steady = ($urandom_range(0, 3) == 0);
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 6);
      now = pick_minute();
      for (int i = 0; i < len; i++) begin
        if (scans % 40 == 7 && i == len / 2) settle_pipe();
        noise = ($urandom_range(0, 19) == 0);
        s.now_minute = MINUTE_W'(noise ? pick_minute() : now);
        if ($urandom_range(0, 1) == 0) begin
          // land near the window edge around the present minute
          off = $urandom_range(0, 2 * window_q + 4) - (int'(window_q) + 2);
          e   = ((clamp_minute(MINUTE_W'(now)) + off) % MINUTES_PER_DAY + MINUTES_PER_DAY)
                % MINUTES_PER_DAY;
          s.entry_minute = MINUTE_W'(e);
        end else begin
          s.entry_minute = MINUTE_W'(pick_minute());
        end
        s.empty_slot = noise ? ($urandom_range(0, 1) == 1) : ($urandom_range(0, 11) == 0);
        s.last_entry = (i == len - 1) ^ (noise && $urandom_range(0, 1));
        push_slot(s, 1'b0, '0);
      end
    end

    settle_pipe();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (due_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", due_results.size()));
    $display("Ran %0d directed slots and %0d random scans, %0d window writes.",
             plan.size(), scans, window_writes);
    $display("Checked %0d result beats: %0d triggers, %0d waits; %0d mismatches.",
             results_seen, triggers_seen, waits_seen, errors);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
